[rtl/cwt_pkg.sv]
// ============================================================================
// cwt_pkg
// Shared constants, operation and state codes, and controller/datapath links
// for the chunk window tracker.
// ============================================================================
package cwt_pkg;

    localparam int DEPTH_DEF   = 256;
    localparam int ID_BITS_DEF = 32;
    localparam int MODE_BITS   = 3;
    localparam int STATE_BITS  = 3;
    localparam int WIN_BITS    = 8;
    localparam int SPAN_BITS   = WIN_BITS + 1;

    // operation codes
    localparam logic [MODE_BITS-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_DEL    = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SET    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_QUERY  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_LEAST  = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_LATEST = 3'd5;

    // chunk state codes
    localparam logic [STATE_BITS-1:0] ST_MISSED = 3'd0;
    localparam logic [STATE_BITS-1:0] ST_PUSH   = 3'd1;
    localparam logic [STATE_BITS-1:0] ST_PULL   = 3'd2;
    localparam logic [STATE_BITS-1:0] ST_SKIP   = 3'd3;
    localparam logic [STATE_BITS-1:0] ST_DELAY  = 3'd4;

    typedef struct packed {
        logic capture;    // latch the incoming item
        logic read_op;    // read the slot of the item's id
        logic exec_op;    // apply add/delete/set/query
        logic scan_init;  // set up a window scan
        logic scan_step;  // advance the window scan
        logic load_out;   // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic is_scan;
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

[rtl/cwt_req_if.sv]
// ============================================================================
// cwt_req_if
// Request channel: one operation item per handshake.
// ============================================================================
interface cwt_req_if #(
    parameter int ID_BITS = cwt_pkg::ID_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [cwt_pkg::MODE_BITS-1:0]  mode;
    logic [ID_BITS-1:0]             chunk_id;
    logic [cwt_pkg::STATE_BITS-1:0] state_in;
    logic [ID_BITS-1:0]             base_id;
    logic [cwt_pkg::WIN_BITS-1:0]   window_len;

    modport source (output valid, mode, chunk_id, state_in, base_id, window_len,
                    input ready);
    modport sink   (input valid, mode, chunk_id, state_in, base_id, window_len,
                    output ready);
endinterface

[rtl/cwt_rsp_if.sv]
// ============================================================================
// cwt_rsp_if
// Response channel: one result item per request item.
// ============================================================================
interface cwt_rsp_if #(
    parameter int ID_BITS  = cwt_pkg::ID_BITS_DEF,
    parameter int CNT_BITS = 9
);
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [ID_BITS-1:0]             found_id;
    logic                           present;
    logic [cwt_pkg::STATE_BITS-1:0] state_out;
    logic [ID_BITS-1:0]             last_id;
    logic [CNT_BITS-1:0]            chunk_count;

    modport source (output valid, ok, found_id, present, state_out, last_id,
                    chunk_count, input ready);
    modport sink   (input valid, ok, found_id, present, state_out, last_id,
                    chunk_count, output ready);
endinterface

[rtl/chunk_window_tracker.sv]
// Add, delete, set state and query pass through dispatch, slot read and execute, then
// wait in done until the output register is free. Window scans visit N ids (at most 256),
// one slot read per cycle, and end at the first missed id or once all N are checked.
// One item at a time; the slot memory read port sets the scan rate.
// Reset (rst_n low, async): all slots read as empty, highest id and count clear.
// No clearing pass: per-slot valid bits in flip-flops cover the reset state.
// ============================================================================
// chunk_window_tracker
// Scoreboard of stream chunk ids in a ring of slots with windowed missed scans.
// ============================================================================
module chunk_window_tracker #(
    parameter int DEPTH   = cwt_pkg::DEPTH_DEF,   // power of two, slot = id mod DEPTH
    parameter int ID_BITS = cwt_pkg::ID_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    cwt_req_if.sink   req,
    cwt_rsp_if.source rsp
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    cwt_pkg::cmd_t    cmd;
    cwt_pkg::status_t status;

    // Controller: idle, dispatch, slot read/execute or scan, then hand off
    // the result to the output register.
    cwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: slot memory with valid bits, highest id, present count,
    // scan pointers and the result register that holds a stalled item.
    cwt_datapath #(
        .DEPTH    (DEPTH),
        .ID_BITS  (ID_BITS),
        .CNT_BITS (CNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (req.mode),
        .chunk_id     (req.chunk_id),
        .state_in     (req.state_in),
        .base_id      (req.base_id),
        .window_len   (req.window_len),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_ok       (rsp.ok),
        .out_found_id (rsp.found_id),
        .out_present  (rsp.present),
        .out_state    (rsp.state_out),
        .out_last_id  (rsp.last_id),
        .out_count    (rsp.chunk_count)
    );

endmodule

[rtl/cwt_ctrl.sv]
// ============================================================================
// cwt_ctrl
// Sequencer: dispatches each item to the slot path or the window scan.
// ============================================================================
module cwt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  cwt_pkg::status_t status,
    output cwt_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_EXEC,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.is_scan)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    cmd.read_op = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec_op = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/cwt_datapath.sv]
// ============================================================================
// cwt_datapath
// Slot memory, valid bits, counters, scan pointers and the output register.
// ============================================================================
module cwt_datapath #(
    parameter int DEPTH    = cwt_pkg::DEPTH_DEF,
    parameter int ID_BITS  = cwt_pkg::ID_BITS_DEF,
    parameter int CNT_BITS = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cwt_pkg::cmd_t                  cmd,
    output cwt_pkg::status_t               status,
    input  logic [cwt_pkg::MODE_BITS-1:0]  mode,
    input  logic [ID_BITS-1:0]             chunk_id,
    input  logic [cwt_pkg::STATE_BITS-1:0] state_in,
    input  logic [ID_BITS-1:0]             base_id,
    input  logic [cwt_pkg::WIN_BITS-1:0]   window_len,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_ok,
    output logic [ID_BITS-1:0]             out_found_id,
    output logic                           out_present,
    output logic [cwt_pkg::STATE_BITS-1:0] out_state,
    output logic [ID_BITS-1:0]             out_last_id,
    output logic [CNT_BITS-1:0]            out_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int SB = cwt_pkg::STATE_BITS;
    localparam int NB = cwt_pkg::SPAN_BITS;

    typedef struct packed {
        logic [ID_BITS-1:0] tag;
        logic               pres;
        logic [SB-1:0]      st;
    } entry_t;

    entry_t               mem [DEPTH];
    logic [DEPTH-1:0]     vld_reg;

    logic [cwt_pkg::MODE_BITS-1:0] mode_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [SB-1:0]        sin_reg;
    logic [ID_BITS-1:0]   low_reg;
    logic [ID_BITS-1:0]   end_reg;

    entry_t               rd_q_reg;
    logic                 rd_v_reg;

    logic [ID_BITS-1:0]   cur_reg;
    logic [NB-1:0]        left_reg;
    logic                 down_reg;
    logic [ID_BITS-1:0]   chk_id_reg;
    logic                 chk_v_reg;

    logic [ID_BITS-1:0]   hi_reg, hi_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;

    logic                 res_ok_reg;
    logic [ID_BITS-1:0]   res_found_reg;
    logic                 res_pres_reg;
    logic [SB-1:0]        res_st_reg;

    logic                 out_v_reg;
    logic                 o_ok_reg;
    logic [ID_BITS-1:0]   o_found_reg;
    logic                 o_pres_reg;
    logic [SB-1:0]        o_st_reg;
    logic [ID_BITS-1:0]   o_last_reg;
    logic [CNT_BITS-1:0]  o_cnt_reg;

    // captured window bounds
    logic [ID_BITS:0]     sum;
    logic [ID_BITS-1:0]   win_end;
    logic [ID_BITS-1:0]   win_low;

    assign sum     = {1'b0, base_id} + {{(ID_BITS + 1 - cwt_pkg::WIN_BITS){1'b0}}, window_len};
    assign win_end = sum[ID_BITS] ? {ID_BITS{1'b1}} : sum[ID_BITS-1:0];
    assign win_low = (base_id == '0) ? {{(ID_BITS-1){1'b0}}, 1'b1} : base_id;

    // memory read port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          issue;

    assign issue   = cmd.scan_step && (left_reg != '0);
    assign rd_en   = cmd.read_op || issue;
    assign rd_addr = cmd.scan_step ? cur_reg[AW-1:0] : id_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
            rd_v_reg <= vld_reg[rd_addr];
        end
    end

    entry_t ent;
    assign ent = rd_v_reg ? rd_q_reg : '0;

    // coverage test for the scanned id
    logic hit_c, cov_c, hit_now;
    assign hit_c   = (ent.tag == chk_id_reg);
    assign cov_c   = hit_c && (ent.pres || ent.st == cwt_pkg::ST_SKIP ||
                               ent.st == cwt_pkg::ST_DELAY);
    assign hit_now = chk_v_reg && !cov_c;

    // slot operation
    logic    hit, p, id_nz, st_rx, st_abs;
    logic    wr_en, ok_c, pres_c;
    logic [SB-1:0] sout_c;
    entry_t  wr_ent;

    assign hit    = (ent.tag == id_reg);
    assign p      = hit && ent.pres;
    assign id_nz  = (id_reg != '0);
    assign st_rx  = (sin_reg == cwt_pkg::ST_PUSH) || (sin_reg == cwt_pkg::ST_PULL);
    assign st_abs = (sin_reg == cwt_pkg::ST_MISSED) || (sin_reg == cwt_pkg::ST_SKIP) ||
                    (sin_reg == cwt_pkg::ST_DELAY);

    always_comb
    begin
        wr_en    = 1'b0;
        wr_ent   = ent;
        ok_c     = 1'b0;
        pres_c   = 1'b0;
        sout_c   = '0;
        cnt_next = cnt_reg;
        hi_next  = hi_reg;
        unique case (mode_reg)
            cwt_pkg::MODE_ADD:
            begin
                if (id_nz && st_rx && !p)
                begin
                    ok_c   = 1'b1;
                    wr_en  = 1'b1;
                    wr_ent = '{tag: id_reg, pres: 1'b1, st: sin_reg};
                    // an evicted present chunk cancels the increment
                    if (hit || !ent.pres)
                        cnt_next = cnt_reg + 1'b1;
                    if (id_reg > hi_reg)
                        hi_next = id_reg;
                end
            end
            cwt_pkg::MODE_DEL:
            begin
                if (id_nz && p)
                begin
                    ok_c        = 1'b1;
                    wr_en       = 1'b1;
                    wr_ent.pres = 1'b0;
                    if (cnt_reg != '0)
                        cnt_next = cnt_reg - 1'b1;
                end
            end
            cwt_pkg::MODE_SET:
            begin
                if (id_nz && ((st_rx && p) || (st_abs && !p)))
                begin
                    ok_c  = 1'b1;
                    wr_en = 1'b1;
                    if (hit)
                        wr_ent.st = sin_reg;
                    else
                    begin
                        wr_ent = '{tag: id_reg, pres: 1'b0, st: sin_reg};
                        if (ent.pres && cnt_reg != '0)
                            cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            cwt_pkg::MODE_QUERY:
            begin
                if (id_nz)
                begin
                    ok_c   = 1'b1;
                    pres_c = p;
                    sout_c = hit ? ent.st : '0;
                end
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_op && wr_en)
            mem[id_reg[AW-1:0]] <= wr_ent;
    end

    // scan setup
    logic [ID_BITS-1:0] top;
    logic               is_down;
    logic [ID_BITS-1:0] diff;
    logic               empty;

    assign is_down = (mode_reg == cwt_pkg::MODE_LATEST);
    assign top     = (end_reg < hi_reg) ? end_reg : hi_reg;
    assign empty   = is_down ? (top < low_reg) : (end_reg < low_reg);
    assign diff    = (is_down ? top : end_reg) - low_reg;

    // input capture and scan pointers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            id_reg   <= chunk_id;
            sin_reg  <= state_in;
            low_reg  <= win_low;
            end_reg  <= win_end;
        end
        if (cmd.scan_init)
        begin
            down_reg <= is_down;
            cur_reg  <= is_down ? top : low_reg;
        end
        else if (issue)
        begin
            cur_reg  <= down_reg ? cur_reg - 1'b1 : cur_reg + 1'b1;
        end
        if (issue)
            chk_id_reg <= cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            hi_reg        <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            chk_v_reg     <= 1'b0;
            res_ok_reg    <= 1'b0;
            res_found_reg <= '0;
            res_pres_reg  <= 1'b0;
            res_st_reg    <= '0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.exec_op)
            begin
                if (wr_en)
                    vld_reg[id_reg[AW-1:0]] <= 1'b1;
                hi_reg        <= hi_next;
                cnt_reg       <= cnt_next;
                res_ok_reg    <= ok_c;
                res_found_reg <= '0;
                res_pres_reg  <= pres_c;
                res_st_reg    <= sout_c;
            end
            if (cmd.scan_init)
            begin
                left_reg      <= empty ? '0 : ({1'b0, diff[NB-2:0]} + 1'b1);
                chk_v_reg     <= 1'b0;
                res_ok_reg    <= 1'b1;
                res_found_reg <= '0;
                res_pres_reg  <= 1'b0;
                res_st_reg    <= '0;
            end
            else if (cmd.scan_step)
            begin
                chk_v_reg <= issue;
                if (issue)
                    left_reg <= left_reg - 1'b1;
                if (hit_now)
                    res_found_reg <= chk_id_reg;
            end
            if (cmd.load_out)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_ok_reg    <= res_ok_reg;
            o_found_reg <= res_found_reg;
            o_pres_reg  <= res_pres_reg;
            o_st_reg    <= res_st_reg;
            o_last_reg  <= hi_reg;
            o_cnt_reg   <= cnt_reg;
        end
    end

    assign status.is_scan   = (mode_reg == cwt_pkg::MODE_LEAST) ||
                              (mode_reg == cwt_pkg::MODE_LATEST);
    assign status.scan_done = hit_now || (left_reg == '0 && !chk_v_reg);
    assign status.out_free  = !out_v_reg || out_ready;

    assign out_valid    = out_v_reg;
    assign out_ok       = o_ok_reg;
    assign out_found_id = o_found_reg;
    assign out_present  = o_pres_reg;
    assign out_state    = o_st_reg;
    assign out_last_id  = o_last_reg;
    assign out_count    = o_cnt_reg;

endmodule

[rtl/cwt_checker.sv]
// ============================================================================
// cwt_checker
// Port-level checks for the chunk window tracker, bound to the top level.
// ============================================================================
module cwt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_ok,
    input logic       rsp_present,
    input logic [2:0] rsp_state,
    input logic       rsp_found_nz
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // one item at a time: drop ready right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item accepted while busy");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> !rsp_present && !rsp_found_nz)
        else $error("failed item carries data");

    a_present_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_present |->
            (rsp_state == cwt_pkg::ST_PUSH || rsp_state == cwt_pkg::ST_PULL))
        else $error("present chunk with non-received state");

endmodule

bind chunk_window_tracker cwt_checker u_cwt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_ok       (rsp.ok),
    .rsp_present  (rsp.present),
    .rsp_state    (rsp.state_out),
    .rsp_found_nz (rsp.found_id != '0)
);

[tb/cwt_result_checker.sv]
// ----------------------------------------------------------------------------
// cwt_result_checker
// Watches the request and response channels of the chunk window tracker,
// keeps its own copy of the slot ring, predicts each response and compares.
// ----------------------------------------------------------------------------
module cwt_result_checker
    import cwt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cwt_req_if    mon_req,
    cwt_rsp_if    mon_rsp,
    output int    error_count,
    output int    outstanding
);

    localparam int SLOTS = DEPTH_DEF;

    typedef struct packed {
        logic                  ok;
        logic [31:0]           found_id;
        logic                  present;
        logic [STATE_BITS-1:0] state_out;
        logic [31:0]           last_id;
        logic [8:0]            chunk_count;
    } answer_t;

    logic [31:0]           ring_tag  [SLOTS];
    logic                  ring_held [SLOTS];
    logic [STATE_BITS-1:0] ring_state[SLOTS];
    logic [31:0]           top_id;
    logic [8:0]            held_count;
    answer_t               pending_answers[$];
    int                    rsp_index;

    function automatic logic chunk_held(logic [31:0] id);
        return ring_tag[id % SLOTS] == id && ring_held[id % SLOTS];
    endfunction

    function automatic logic [STATE_BITS-1:0] slot_state_of(logic [31:0] id);
        return (ring_tag[id % SLOTS] == id) ? ring_state[id % SLOTS] : ST_MISSED;
    endfunction

    function automatic logic chunk_covered(logic [31:0] id);
        logic [STATE_BITS-1:0] s;
        s = slot_state_of(id);
        return chunk_held(id) || s == ST_SKIP || s == ST_DELAY;
    endfunction

    // Take over the slot for a new id; drop whatever it held.
    task automatic claim_slot(input logic [31:0] id);
        int s;
        s = id % SLOTS;
        if (ring_tag[s] != id)
        begin
            if (ring_held[s] && held_count > 0)
                held_count--;
            ring_tag[s]   = id;
            ring_held[s]  = 1'b0;
            ring_state[s] = ST_MISSED;
        end
    endtask

    task automatic apply_request(output answer_t a);
        logic [31:0]           id;
        logic [STATE_BITS-1:0] st;
        logic [32:0]           win_end;
        logic [32:0]           low;
        logic [32:0]           top;
        logic [32:0]           i;
        logic                  p;
        id      = mon_req.chunk_id;
        st      = mon_req.state_in;
        win_end = {1'b0, mon_req.base_id} + mon_req.window_len;
        if (win_end > 33'hFFFF_FFFF)
            win_end = 33'hFFFF_FFFF;
        low = (mon_req.base_id == 0) ? 33'd1 : {1'b0, mon_req.base_id};
        a = '0;
        case (mon_req.mode)
            MODE_ADD:
                if (id != 0 && (st == ST_PUSH || st == ST_PULL) && !chunk_held(id))
                begin
                    claim_slot(id);
                    ring_held[id % SLOTS]  = 1'b1;
                    ring_state[id % SLOTS] = st;
                    held_count++;
                    if (id > top_id)
                        top_id = id;
                    a.ok = 1'b1;
                end
            MODE_DEL:
                if (id != 0 && chunk_held(id))
                begin
                    ring_held[id % SLOTS] = 1'b0;
                    if (held_count > 0)
                        held_count--;
                    a.ok = 1'b1;
                end
            MODE_SET:
                if (id != 0)
                begin
                    p = chunk_held(id);
                    if (((st == ST_PUSH || st == ST_PULL) && p) ||
                        ((st == ST_MISSED || st == ST_SKIP || st == ST_DELAY) && !p))
                    begin
                        claim_slot(id);
                        ring_state[id % SLOTS] = st;
                        a.ok = 1'b1;
                    end
                end
            MODE_QUERY:
                if (id != 0)
                begin
                    a.present   = chunk_held(id);
                    a.state_out = slot_state_of(id);
                    a.ok        = 1'b1;
                end
            MODE_LEAST:
            begin
                for (i = low; i <= win_end; i++)
                    if (!chunk_covered(i[31:0]))
                    begin
                        a.found_id = i[31:0];
                        break;
                    end
                a.ok = 1'b1;
            end
            MODE_LATEST:
            begin
                top = (win_end < {1'b0, top_id}) ? win_end : {1'b0, top_id};
                for (i = top; i >= low; i--)
                    if (!chunk_covered(i[31:0]))
                    begin
                        a.found_id = i[31:0];
                        break;
                    end
                a.ok = 1'b1;
            end
            default: ;
        endcase
        a.last_id     = top_id;
        a.chunk_count = held_count;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                ring_tag[k]   = '0;
                ring_held[k]  = 1'b0;
                ring_state[k] = ST_MISSED;
            end
            top_id      = '0;
            held_count  = '0;
            error_count = 0;
            rsp_index   = 0;
            pending_answers.delete();
            outstanding = 0;
        end
        else
        begin
            // Check the response first; it always belongs to an older item.
            if (mon_rsp.valid && mon_rsp.ready)
            begin
                got = '{mon_rsp.ok, mon_rsp.found_id, mon_rsp.present,
                        mon_rsp.state_out, mon_rsp.last_id, mon_rsp.chunk_count};
                if (pending_answers.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected response %0d: %p", rsp_index, got);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch on response %0d:\n  expected %p\n  actual   %p",
                                     rsp_index, want, got);
                    end
                end
                rsp_index++;
            end
            if (mon_req.valid && mon_req.ready)
            begin
                apply_request(want);
                pending_answers.push_back(want);
            end
            outstanding = pending_answers.size();
        end
    end

endmodule

[tb/tb_chunk_window_tracker.sv]
// ----------------------------------------------------------------------------
// tb_chunk_window_tracker
// Drives directed and random operations into the chunk window tracker under
// several idle/stall mixes; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_chunk_window_tracker;
    import cwt_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 5000;   // a scan plus long stalls stays far below

    logic clk;
    logic rst_n;
    int   error_count;
    int   outstanding;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   items_sent;
    int   scans_sent;
    int   idle_cycles;
    logic [31:0] id_region;

    cwt_req_if req ();
    cwt_rsp_if rsp ();

    chunk_window_tracker i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    cwt_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .mon_req     (req),
        .mon_rsp     (rsp),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: stall at random according to the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Present one item, hold it until accepted, then maybe leave a gap.
    // Valid is only dropped when a gap follows, never lowered and raised in one step.
    task automatic send_op(input logic [2:0] mode, input logic [31:0] id,
                           input logic [2:0] st, input logic [31:0] base,
                           input logic [7:0] win);
        int gap;
        req.valid      <= 1'b1;
        req.mode       <= mode;
        req.chunk_id   <= id;
        req.state_in   <= st;
        req.base_id    <= base;
        req.window_len <= win;
        do
            @(posedge clk);
        while (!req.ready);
        items_sent++;
        if (mode == MODE_LEAST || mode == MODE_LATEST)
            scans_sent++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender until every expected response has come back.
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Ids cluster around a region so slots collide, evict and scans find things.
    function automatic logic [31:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return 32'd0;
        if (r < 6)
            return $urandom;
        return id_region + $urandom_range(0, 600);
    endfunction

    task automatic send_random();
        int          r;
        logic [2:0]  mode;
        logic [2:0]  st;
        logic [31:0] base;
        r = $urandom_range(99);
        if (r < 35)      mode = MODE_ADD;
        else if (r < 50) mode = MODE_DEL;
        else if (r < 65) mode = MODE_SET;
        else if (r < 78) mode = MODE_QUERY;
        else if (r < 87) mode = MODE_LEAST;
        else if (r < 96) mode = MODE_LATEST;
        else             mode = 3'($urandom_range(6, 7));
        if ($urandom_range(9) == 0)
            st = 3'($urandom_range(0, 7));
        else if (mode == MODE_ADD)
            st = 3'($urandom_range(ST_PUSH, ST_PULL));
        else
            st = 3'($urandom_range(ST_MISSED, ST_DELAY));
        base = ($urandom_range(19) == 0) ? $urandom : id_region + $urandom_range(0, 500);
        send_op(mode, pick_id(), st, base, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        id_region = ($urandom_range(3) == 0) ? 32'hFFFF_FD00 : $urandom_range(1, 5000);
        for (int k = 0; k < n; k++)
        begin
            send_random();
            // Pause once mid-phase until the block has answered everything.
            if (k == n / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.mode       = MODE_ADD;
        req.chunk_id   = '0;
        req.state_in   = ST_MISSED;
        req.base_id    = '0;
        req.window_len = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        scans_sent     = 0;
        idle_cycles    = 0;
        id_region      = 32'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, failing and rule-breaking cases.
        send_op(MODE_ADD,    32'd1,          ST_PUSH,  '0, 8'd0);
        send_op(MODE_ADD,    32'hFFFF_FFFF,  ST_PULL,  '0, 8'd0);
        send_op(MODE_ADD,    32'd1,          ST_PULL,  '0, 8'd0);   // already held
        send_op(MODE_ADD,    32'd5,          ST_MISSED, '0, 8'd0);  // bad add state
        send_op(MODE_ADD,    32'd0,          ST_PUSH,  '0, 8'd0);   // zero id
        send_op(MODE_QUERY,  32'd0,          ST_MISSED, '0, 8'd0);
        send_op(MODE_DEL,    32'd7,          ST_MISSED, '0, 8'd0);  // not held
        send_op(MODE_ADD,    32'd3,          ST_PUSH,  '0, 8'd0);
        send_op(MODE_DEL,    32'd3,          ST_MISSED, '0, 8'd0);
        send_op(MODE_QUERY,  32'd3,          ST_MISSED, '0, 8'd0);  // state kept
        send_op(MODE_SET,    32'd4,          ST_SKIP,  '0, 8'd0);
        send_op(MODE_SET,    32'd6,          ST_DELAY, '0, 8'd0);
        send_op(MODE_SET,    32'd1,          ST_PULL,  '0, 8'd0);
        send_op(MODE_SET,    32'd1,          ST_SKIP,  '0, 8'd0);   // breaks the rule
        send_op(MODE_SET,    32'd2,          3'd7,     '0, 8'd0);   // undefined code
        send_op(MODE_ADD,    32'd257,        ST_PUSH,  '0, 8'd0);   // evicts id 1
        send_op(MODE_QUERY,  32'd1,          ST_MISSED, '0, 8'd0);
        send_op(MODE_LEAST,  32'd0,          ST_MISSED, 32'd0, 8'd255);
        send_op(MODE_LATEST, 32'd0,          ST_MISSED, 32'd0, 8'd255);
        send_op(MODE_LEAST,  32'd0,          ST_MISSED, 32'hFFFF_FF80, 8'd255);
        send_op(MODE_LATEST, 32'd0,          ST_MISSED, 32'hFFFF_FF80, 8'd255);
        send_op(MODE_LATEST, 32'd0,          ST_MISSED, 32'd400, 8'd3);  // window below top id
        send_op(3'd6,        32'd9,          ST_PUSH,  '0, 8'd0);
        send_op(3'd7,        32'd9,          ST_PUSH,  '0, 8'd0);
        drain();

        random_phase(RANDOM_ITEMS / 4,  0,  0);
        random_phase(RANDOM_ITEMS / 4, 56,  0);
        random_phase(RANDOM_ITEMS / 4,  0, 56);
        random_phase(RANDOM_ITEMS / 4, 23, 23);

        repeat (300) @(posedge clk);
        $display("run covered %0d items, %0d of them window scans, over four idle/stall mixes",
                 items_sent, scans_sent);
        if (error_count == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
